@@ design/ctu_pkg.sv @@
// ----------------------------------------------------------------------------
// CORDIC trig unit package
// Request and result types, controller states, commands and the fixed-point
// constants (16 fraction bits, 16 CORDIC iterations).
// ----------------------------------------------------------------------------
package ctu_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ITERATIONS = 16;
    localparam int IDX_W      = 4;
    // quotient bits of |angle| / 2pi for a 32-bit magnitude
    localparam int QUOT_BITS  = 13;

    localparam logic signed [DATA_W-1:0] TWO_PI_Q  = 32'sd411775;
    localparam logic signed [DATA_W-1:0] PI_Q      = 32'sd205887;
    localparam logic signed [DATA_W-1:0] HALF_PI_Q = 32'sd102944;
    localparam logic signed [DATA_W-1:0] ONE_Q     = 32'sd65536;
    localparam logic [15:0]              GAIN_Q    = 16'd39797;

    localparam logic [IDX_W-1:0] RED_FIRST = IDX_W'(QUOT_BITS - 1);
    localparam logic [IDX_W-1:0] ITER_LAST = IDX_W'(ITERATIONS - 1);

    typedef enum logic [2:0] {
        OP_ROTATE  = 3'd0,
        OP_SINCOS  = 3'd1,
        OP_ATAN    = 3'd2,
        OP_ATAN2   = 3'd3,
        OP_LENGTH  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_FOLD_PI,
        S_FOLD_HALF,
        S_ITER,
        S_GAIN_X,
        S_GAIN_Y,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic signed [DATA_W-1:0] angle_in;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_x;
        logic signed [DATA_W-1:0] result_y;
        logic signed [DATA_W-1:0] result_angle;
    } t_res;

    typedef struct packed {
        logic             load;
        logic             reduce;
        logic             fold_pi;
        logic             fold_half;
        logic             iter_rot;
        logic             iter_vec;
        logic             gain_x;
        logic             gain_y;
        logic             emit;
        logic [IDX_W-1:0] idx;
        logic [2:0]       op;
    } t_cmd;

    // round(atan(2^-i)) in Q16
    function automatic logic signed [DATA_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
        logic signed [DATA_W-1:0] v;
        case (i)
            4'd0:    v = 32'sd51472;
            4'd1:    v = 32'sd30386;
            4'd2:    v = 32'sd16055;
            4'd3:    v = 32'sd8150;
            4'd4:    v = 32'sd4091;
            4'd5:    v = 32'sd2047;
            4'd6:    v = 32'sd1024;
            4'd7:    v = 32'sd512;
            4'd8:    v = 32'sd256;
            4'd9:    v = 32'sd128;
            4'd10:   v = 32'sd64;
            4'd11:   v = 32'sd32;
            4'd12:   v = 32'sd16;
            4'd13:   v = 32'sd8;
            4'd14:   v = 32'sd4;
            4'd15:   v = 32'sd2;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/cordic_trig_unit_top.sv @@
// ----------------------------------------------------------------------------
// CORDIC trig unit
// Shift-add CORDIC rotate, sine/cosine, arctangent, atan2 and vector length.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its single result appears on o_res with o_valid high for exactly
// one cycle, in the same cycle that busy falls; the receiver cannot stall it.
// Busy stays high while a request is worked on. The work is done by the
// single shared CORDIC adder stage (16 micro-rotations, one per cycle),
// preceded for rotate and sine/cosine by a restoring reduction of the angle
// modulo 2pi and a fold by pi and by pi/2, and followed by gain scaling on
// the shared gain multiplier (x and y for rotate, x for length); an undefined
// operation goes straight to its all-zero result. A new request may be given in
// the same cycle that the previous result is shown.
// ----------------------------------------------------------------------------
module cordic_trig_unit_top
    import ctu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    t_cmd cmd;

    ctu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_req.operation),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    ctu_datapath u_datapath (
        .i_clk (i_clk),
        .i_req (i_req),
        .i_cmd (cmd),
        .o_res (o_res)
    );

endmodule

@@ design/ctu_ctrl.sv @@
// ----------------------------------------------------------------------------
// CORDIC trig unit controller
// Sequences angle reduction, folding, CORDIC iterations and gain scaling,
// and drives the datapath with one command word per cycle.
// ----------------------------------------------------------------------------
module ctu_ctrl
    import ctu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_op,
    output logic       busy,
    output logic       o_valid,
    output t_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_op, n_op;
    logic             r_valid;
    logic             accept;
    logic             rot_mode;

    assign accept   = start && (r_state == S_IDLE);
    assign rot_mode = (r_op == OP_ROTATE) || (r_op == OP_SINCOS);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_op;
                    case (i_op) inside
                        OP_ROTATE, OP_SINCOS: begin
                            n_state = S_REDUCE;
                            n_cnt   = RED_FIRST;
                        end
                        OP_ATAN, OP_ATAN2, OP_LENGTH: begin
                            n_state = S_ITER;
                            n_cnt   = '0;
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_REDUCE: begin
                if (r_cnt == '0) begin
                    n_state = S_FOLD_PI;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FOLD_PI:   n_state = S_FOLD_HALF;
            S_FOLD_HALF: begin
                n_state = S_ITER;
                n_cnt   = '0;
            end
            S_ITER: begin
                if (r_cnt == ITER_LAST) begin
                    if ((r_op == OP_ROTATE) || (r_op == OP_LENGTH)) begin
                        n_state = S_GAIN_X;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_GAIN_X: n_state = (r_op == OP_ROTATE) ? S_GAIN_Y : S_EMIT;
            S_GAIN_Y: n_state = S_EMIT;
            S_EMIT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_cnt;
        o_cmd.op        = r_op;
        o_cmd.load      = accept;
        case (r_state)
            S_REDUCE:    o_cmd.reduce    = 1'b1;
            S_FOLD_PI:   o_cmd.fold_pi   = 1'b1;
            S_FOLD_HALF: o_cmd.fold_half = 1'b1;
            S_ITER: begin
                o_cmd.iter_rot = rot_mode;
                o_cmd.iter_vec = !rot_mode;
            end
            S_GAIN_X:    o_cmd.gain_x    = 1'b1;
            S_GAIN_Y:    o_cmd.gain_y    = 1'b1;
            S_EMIT:      o_cmd.emit      = 1'b1;
            default:     o_cmd.emit      = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_op    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
            r_valid <= (r_state == S_EMIT);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_EMIT))
        else $error("result strobe without a preceding emit");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while still busy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted request did not start work");

    a_iter_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && r_cnt != ITER_LAST) |=>
            (r_state == S_ITER && r_cnt == $past(r_cnt) + 1'b1))
        else $error("CORDIC iteration sequence broken");

endmodule

@@ design/ctu_datapath.sv @@
// ----------------------------------------------------------------------------
// CORDIC trig unit datapath
// Holds the vector, the angle and the reduction remainder; one restoring
// step, one fold, one CORDIC micro-rotation or one gain multiply per cycle.
// ----------------------------------------------------------------------------
module ctu_datapath
    import ctu_pkg::*;
(
    input  logic i_clk,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_res o_res
);

    logic signed [DATA_W-1:0] r_x, n_x;
    logic signed [DATA_W-1:0] r_y, n_y;
    logic signed [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0]        r_rem, n_rem;
    logic                     r_neg, n_neg;
    t_res                     r_res, n_res;

    logic [DATA_W-1:0]        ang_mag;
    logic [DATA_W-1:0]        div_step;
    logic signed [DATA_W-1:0] a_red;
    logic signed [DATA_W-1:0] sh_x, sh_y, atan_i;
    logic signed [DATA_W-1:0] mul_in;
    logic signed [47:0]       prod;
    logic signed [DATA_W-1:0] gain_out;

    assign ang_mag  = i_req.angle_in[DATA_W-1] ? (32'd0 - i_req.angle_in) : i_req.angle_in;
    assign div_step = TWO_PI_Q << i_cmd.idx;
    assign a_red    = r_neg ? (32'sd0 - $signed(r_rem)) : $signed(r_rem);
    assign sh_x     = r_x >>> i_cmd.idx;
    assign sh_y     = r_y >>> i_cmd.idx;
    assign atan_i   = atan_entry(i_cmd.idx);
    assign mul_in   = i_cmd.gain_y ? r_y : r_x;
    assign prod     = 48'(mul_in) * 48'($signed({1'b0, GAIN_Q}));
    assign gain_out = prod[47:16];

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_a   = r_a;
        n_rem = r_rem;
        n_neg = r_neg;
        n_res = r_res;

        if (i_cmd.load) begin
            n_x   = i_req.x_in;
            n_y   = i_req.y_in;
            n_a   = '0;
            n_rem = ang_mag;
            n_neg = i_req.angle_in[DATA_W-1];
            case (i_req.operation) inside
                OP_SINCOS: begin
                    n_x = $signed({16'd0, GAIN_Q});
                    n_y = '0;
                end
                OP_ATAN:   n_x = ONE_Q;
                OP_ATAN2: begin
                    if (i_req.x_in[DATA_W-1]) begin
                        n_a = (i_req.y_in > 32'sd0) ? PI_Q : (32'sd0 - PI_Q);
                        n_x = 32'sd0 - i_req.x_in;
                        n_y = 32'sd0 - i_req.y_in;
                    end
                end
                OP_LENGTH: begin
                    if (i_req.x_in[DATA_W-1]) begin
                        n_x = 32'sd0 - i_req.x_in;
                    end
                end
                default: n_a = '0;
            endcase
        end

        // restoring step of |angle| mod 2pi
        if (i_cmd.reduce && (r_rem >= div_step)) begin
            n_rem = r_rem - div_step;
        end

        if (i_cmd.fold_pi) begin
            n_a = a_red;
            if (a_red >= PI_Q) begin
                n_x = 32'sd0 - r_x;
                n_y = 32'sd0 - r_y;
                n_a = a_red - PI_Q;
            end else if (a_red <= (32'sd0 - PI_Q)) begin
                n_x = 32'sd0 - r_x;
                n_y = 32'sd0 - r_y;
                n_a = a_red + PI_Q;
            end
        end

        if (i_cmd.fold_half) begin
            if (r_a >= HALF_PI_Q) begin
                n_x = 32'sd0 - r_y;
                n_y = r_x;
                n_a = r_a - HALF_PI_Q;
            end else if (r_a <= (32'sd0 - HALF_PI_Q)) begin
                n_x = r_y;
                n_y = 32'sd0 - r_x;
                n_a = r_a + HALF_PI_Q;
            end
        end

        if (i_cmd.iter_rot) begin
            if (r_a[DATA_W-1]) begin
                n_x = r_x + sh_y;
                n_y = r_y - sh_x;
                n_a = r_a + atan_i;
            end else begin
                n_x = r_x - sh_y;
                n_y = r_y + sh_x;
                n_a = r_a - atan_i;
            end
        end

        if (i_cmd.iter_vec) begin
            if (r_y[DATA_W-1]) begin
                n_x = r_x - sh_y;
                n_y = r_y + sh_x;
                n_a = r_a - atan_i;
            end else begin
                n_x = r_x + sh_y;
                n_y = r_y - sh_x;
                n_a = r_a + atan_i;
            end
        end

        if (i_cmd.gain_x) begin
            n_x = gain_out;
        end
        if (i_cmd.gain_y) begin
            n_y = gain_out;
        end

        if (i_cmd.emit) begin
            n_res = '0;
            case (i_cmd.op) inside
                OP_ROTATE, OP_SINCOS: begin
                    n_res.result_x = r_x;
                    n_res.result_y = r_y;
                end
                OP_ATAN, OP_ATAN2: n_res.result_angle = r_a;
                OP_LENGTH:         n_res.result_x     = r_x;
                default:           n_res              = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_a   <= n_a;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

@@ sim/cordic_trig_unit_top_tb.sv @@
// ----------------------------------------------------------------------------
// CORDIC trig unit testbench
// Drives rotate, sine/cosine, arctangent, atan2, length and undefined requests
// through the start/busy handshake, with directed corners first and random
// requests after. A scoreboard works out each result bit for bit and checks
// every strobed result in order.
// ----------------------------------------------------------------------------
module cordic_trig_unit_top_tb;
    import ctu_pkg::*;

    localparam int RANDOM_REQS = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

    // Q16 constants
    localparam logic signed [31:0] FX_TWO_PI  = 32'sd411775;
    localparam logic signed [31:0] FX_PI      = 32'sd205887;
    localparam logic signed [31:0] FX_HALF_PI = 32'sd102944;
    localparam logic signed [31:0] FX_ONE     = 32'sd65536;
    localparam logic signed [31:0] FX_GAIN    = 32'sd39797;
    localparam logic signed [31:0] FX_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FX_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] ATAN_STEP [16] = '{
        32'sd51472, 32'sd30386, 32'sd16055, 32'sd8150, 32'sd4091, 32'sd2047,
        32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16,
        32'sd8, 32'sd4, 32'sd2
    };

    class trig_scoreboard;
        t_res        pending_results[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // (v * G) >> 16, floored, low 32 bits
        function logic signed [31:0] scale_by_gain(input logic signed [31:0] v);
            longint p;
            p = longint'(v) * longint'(FX_GAIN);
            return p[47:16];
        endfunction

        function t_res trig_result_of(input t_req r);
            t_res res;
            logic signed [31:0] x, y, a, t, dx, dy;
            longint ang;
            res = '0;
            x = r.x_in;
            y = r.y_in;
            a = '0;
            case (r.operation)
                OP_ROTATE, OP_SINCOS: begin
                    if (r.operation == OP_SINCOS) begin
                        x = FX_GAIN;
                        y = '0;
                    end
                    ang = longint'($signed(r.angle_in));
                    // drop whole turns, keeping the sign
                    if (ang >= FX_TWO_PI || ang <= -longint'(FX_TWO_PI))
                        ang = ang % longint'(FX_TWO_PI);
                    if (ang >= FX_PI) begin
                        x = -x; y = -y; ang = ang - FX_PI;
                    end
                    if (ang <= -longint'(FX_PI)) begin
                        x = -x; y = -y; ang = ang + FX_PI;
                    end
                    if (ang >= FX_HALF_PI) begin
                        t = x; x = -y; y = t; ang = ang - FX_HALF_PI;
                    end
                    if (ang <= -longint'(FX_HALF_PI)) begin
                        t = x; x = y; y = -t; ang = ang + FX_HALF_PI;
                    end
                    a = ang[31:0];
                    for (int i = 0; i < 16; i++) begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (a[31]) begin
                            x = x + dx; y = y - dy; a = a + ATAN_STEP[i];
                        end else begin
                            x = x - dx; y = y + dy; a = a - ATAN_STEP[i];
                        end
                    end
                    if (r.operation == OP_ROTATE) begin
                        res.result_x = scale_by_gain(x);
                        res.result_y = scale_by_gain(y);
                    end else begin
                        res.result_x = x;
                        res.result_y = y;
                    end
                end
                OP_ATAN, OP_ATAN2, OP_LENGTH: begin
                    if (r.operation == OP_ATAN) begin
                        x = FX_ONE;
                    end else if (r.operation == OP_ATAN2 && x[31]) begin
                        // fold the left half plane, negation wraps
                        a = (y > 0) ? FX_PI : -FX_PI;
                        x = -x;
                        y = -y;
                    end else if (r.operation == OP_LENGTH && x[31]) begin
                        x = -x;
                    end
                    for (int i = 0; i < 16; i++) begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (y[31]) begin
                            x = x - dx; y = y + dy; a = a - ATAN_STEP[i];
                        end else begin
                            x = x + dx; y = y - dy; a = a + ATAN_STEP[i];
                        end
                    end
                    if (r.operation == OP_LENGTH)
                        res.result_x = scale_by_gain(x);
                    else
                        res.result_angle = a;
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_request(input t_req r);
            pending_results.push_back(trig_result_of(r));
        endfunction

        function void check_result(input t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: x=%0d y=%0d angle=%0d",
                       got.result_x, got.result_y, got.result_angle);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_x !== want.result_x) begin
                $error("result_x: expected %0d, got %0d", want.result_x, got.result_x);
                errors++;
            end
            if (got.result_y !== want.result_y) begin
                $error("result_y: expected %0d, got %0d", want.result_y, got.result_y);
                errors++;
            end
            if (got.result_angle !== want.result_angle) begin
                $error("result_angle: expected %0d, got %0d",
                       want.result_angle, got.result_angle);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_valid;
    t_res o_res;

    trig_scoreboard sb;
    bit             no_idle;
    int unsigned    cycles;

    cordic_trig_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // sample on the rising edge: check the strobed result, then note a taken request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_res);
            if (start && !busy)
                sb.note_request(i_req);
        end
    end

    function automatic t_req make_req(input logic [2:0] op, input logic signed [31:0] x,
                                      input logic signed [31:0] y,
                                      input logic signed [31:0] ang);
        t_req r;
        r.operation = op;
        r.x_in      = x;
        r.y_in      = y;
        r.angle_in  = ang;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return int'($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
            8: begin
                case ($urandom_range(5))
                    0: return '0;
                    1: return FX_MIN;
                    2: return FX_MAX;
                    3: return -32'sd1;
                    4: return FX_ONE;
                    default: return -FX_ONE;
                endcase
            end
            default: return int'($urandom_range(255)) - 128;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range(32'hF_FFFF)) - 32'sh8_0000;
            // land on or next to a fold boundary
            2: return FX_HALF_PI * (int'($urandom_range(16)) - 8)
                      + (int'($urandom_range(4)) - 2);
            default: return rand_operand();
        endcase
    endfunction

    function automatic t_req rand_req();
        logic [2:0] op;
        if ($urandom_range(99) < 4)
            op = 3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
        else
            op = 3'($urandom_range(OP_LENGTH));
        return make_req(op, rand_operand(), rand_operand(), rand_angle());
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_req(input t_req r);
        while (!no_idle && $urandom_range(99) < 25) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        sb      = new();
        cycles  = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_req(make_req(OP_ROTATE, FX_ONE, '0, '0));
        send_req(make_req(OP_ROTATE, FX_ONE, FX_ONE, FX_HALF_PI));
        send_req(make_req(OP_ROTATE, FX_ONE, -FX_ONE, -FX_HALF_PI));
        send_req(make_req(OP_ROTATE, FX_ONE, '0, FX_PI));
        send_req(make_req(OP_ROTATE, FX_ONE, '0, -FX_PI));
        send_req(make_req(OP_ROTATE, FX_MAX, FX_MAX, FX_TWO_PI));
        send_req(make_req(OP_ROTATE, FX_MIN, FX_MIN, -FX_TWO_PI));
        send_req(make_req(OP_ROTATE, FX_ONE, FX_ONE, FX_MAX));
        send_req(make_req(OP_ROTATE, FX_MIN, FX_MAX, FX_MIN));
        send_req(make_req(OP_SINCOS, '0, '0, '0));
        send_req(make_req(OP_SINCOS, FX_MAX, FX_MIN, FX_HALF_PI - 1));
        send_req(make_req(OP_SINCOS, '0, '0, FX_MIN));
        send_req(make_req(OP_ATAN, '0, '0, '0));
        send_req(make_req(OP_ATAN, FX_MIN, FX_MAX, FX_MAX));
        send_req(make_req(OP_ATAN, '0, FX_MIN, '0));
        // left half plane folds and the origin for atan2
        send_req(make_req(OP_ATAN2, -FX_ONE, FX_ONE, '0));
        send_req(make_req(OP_ATAN2, -FX_ONE, '0, '0));
        send_req(make_req(OP_ATAN2, FX_MIN, FX_MIN, '0));
        send_req(make_req(OP_ATAN2, '0, '0, '0));
        // length: most negative x wraps through the absolute value, then a 3-4-5 case and the largest operands
        send_req(make_req(OP_LENGTH, FX_MIN, '0, '0));
        send_req(make_req(OP_LENGTH, -3 * FX_ONE, 4 * FX_ONE, '0));
        send_req(make_req(OP_LENGTH, FX_MAX, FX_MAX, FX_MAX));
        send_req(make_req(OP_UNDEF_FIRST, FX_MAX, FX_MAX, FX_MAX));
        send_req(make_req(OP_UNDEF_LAST, FX_MIN, FX_MIN, FX_MIN));
        drain();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            no_idle = (n >= 500 && n < 700);
            if (n == 300 || n == 900)
                drain();
            send_req(rand_req());
        end

        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
